### design/tef_pkg.sv
// tef_pkg: shared types, constants and the cordic angle table for the tilt estimator
// no dependencies
package tef_pkg;

  localparam int unsigned OneGCounts    = 16384;
  localparam int unsigned AngleFracBits = 16;
  localparam int unsigned TabFrac       = 20;
  localparam int unsigned CordicSteps   = 20;
  localparam int unsigned SineShift     = 30;
  localparam logic [63:0] CordicK       = 64'd652032874;
  localparam logic [7:0]  FrameHeader   = 8'hAA;
  localparam int unsigned FrameLen      = 13;

  localparam logic [2:0] RegOffsetX = 3'd0;
  localparam logic [2:0] RegOffsetY = 3'd1;
  localparam logic [2:0] RegOffsetZ = 3'd2;
  localparam logic [2:0] RegGain    = 3'd3;
  localparam logic [2:0] RegArm     = 3'd4;
  localparam logic [2:0] RegAvg     = 3'd5;

  typedef struct packed {
    logic signed [15:0] coarse_x;
    logic signed [15:0] coarse_y;
    logic signed [15:0] coarse_z;
    logic signed [19:0] fine_x;
    logic signed [19:0] fine_y;
    logic signed [19:0] fine_z;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_word_t;

  // corrected operands handed from the front to the back
  typedef struct packed {
    logic signed [20:0] cx;
    logic signed [20:0] cy;
    logic signed [20:0] cz;
    logic signed [20:0] fx;
    logic signed [20:0] fy;
    logic signed [20:0] fz;
  } job_t;

  function automatic logic [27:0] atan_tab(input logic [4:0] i);
    logic [27:0] r;
    begin
      case (i)
        5'd0:  r = 28'd47185920;
        5'd1:  r = 28'd27855475;
        5'd2:  r = 28'd14718068;
        5'd3:  r = 28'd7471121;
        5'd4:  r = 28'd3750058;
        5'd5:  r = 28'd1876857;
        5'd6:  r = 28'd938658;
        5'd7:  r = 28'd469357;
        5'd8:  r = 28'd234682;
        5'd9:  r = 28'd117342;
        5'd10: r = 28'd58671;
        5'd11: r = 28'd29335;
        5'd12: r = 28'd14668;
        5'd13: r = 28'd7334;
        5'd14: r = 28'd3667;
        5'd15: r = 28'd1833;
        5'd16: r = 28'd917;
        5'd17: r = 28'd458;
        5'd18: r = 28'd229;
        5'd19: r = 28'd115;
        default: r = 28'd0;
      endcase
      return r;
    end
  endfunction

endpackage

### design/tef_front.sv
// tef_front: accepts a sample word, applies coarse offsets and one g, pushes a job
// depends on tef_pkg
module tef_front #(
  parameter int unsigned OneG = tef_pkg::OneGCounts
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  tef_pkg::in_word_t  in_data_i,
  input  logic signed [15:0] off_x_i,
  input  logic signed [15:0] off_y_i,
  input  logic signed [15:0] off_z_i,
  output logic               job_valid_o,
  input  logic               job_pop_i,
  output tef_pkg::job_t      job_o
);

  // two-entry queue between front and back
  tef_pkg::job_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  tef_pkg::job_t job_d;
  logic          push;

  assign in_stall = (cnt_q == 2'd2);
  assign push     = in_valid && !in_stall;

  always_comb begin
    job_d.cx = 21'(in_data_i.coarse_x) - 21'(off_x_i);
    job_d.cy = 21'(in_data_i.coarse_y) - 21'(off_y_i);
    job_d.cz = 21'(in_data_i.coarse_z) - 21'(off_z_i) + 21'(OneG);
    job_d.fx = 21'(in_data_i.fine_x);
    job_d.fy = 21'(in_data_i.fine_y);
    job_d.fz = 21'(in_data_i.fine_z);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= job_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (job_pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(job_pop_i);
    end
  end

  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = mem_q[rd_ptr_q];

endmodule

### design/tef_cordic.sv
// tef_cordic: shared iterative cordic, vectoring (atan2 in degrees) or rotation (sine)
// depends on tef_pkg
module tef_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               rot_i,
  input  logic signed [21:0] num_i,
  input  logic signed [21:0] den_i,
  input  logic signed [31:0] ang_i,
  output logic               done_o,
  output logic signed [63:0] y_o,
  output logic signed [31:0] ang_o
);

  logic signed [63:0] x_q, y_q, z_q;
  logic [4:0]         i_q;
  logic               busy_q, rot_q, zero_q;
  logic               dir;
  logic signed [63:0] dx, dy, t, zr;

  assign dx  = y_q >>> i_q;
  assign dy  = x_q >>> i_q;
  assign t   = 64'(tef_pkg::atan_tab(i_q));
  assign dir = rot_q ? (z_q >= 0) : (y_q < 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      i_q    <= '0;
      rot_q  <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
        rot_q  <= rot_i;
        zero_q <= (num_i == 0);
      end else if (busy_q) begin
        i_q <= i_q + 5'd1;
        if (i_q == 5'(tef_pkg::CordicSteps - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (rot_i) begin
        x_q <= $signed(tef_pkg::CordicK);
        y_q <= '0;
        z_q <= 64'(ang_i) <<< (tef_pkg::TabFrac - tef_pkg::AngleFracBits);
      end else begin
        x_q <= 64'(den_i) <<< 16;
        y_q <= 64'(num_i) <<< 16;
        z_q <= '0;
      end
    end else if (busy_q) begin
      // dir high: x-dx, y+dy, z-t in rotation; x-dx, y+dy, z-t in vectoring with y<0
      if (dir) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - t;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + t;
      end
    end
  end

  assign zr    = (z_q + 64'sd8) >>> (tef_pkg::TabFrac - tef_pkg::AngleFracBits);
  assign ang_o = zero_q ? 32'sd0 : 32'(zr);
  assign y_o   = y_q;

endmodule

### design/tef_div.sv
// tef_div: restoring signed divider, truncating quotient, one bit a cycle
// no dependencies
module tef_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic [31:0]        den_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);

  logic [63:0] q_q;
  logic [31:0] r_q;
  logic [31:0] d_q;
  logic [6:0]  i_q;
  logic        neg_q, busy_q;
  logic [32:0] rs;

  assign rs = {r_q, q_q[63]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      i_q    <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 7'd1;
        if (i_q == 7'd63) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i[63] ? 64'(-num_i) : 64'(num_i);
      neg_q <= num_i[63];
      r_q   <= '0;
      d_q   <= den_i;
    end else if (busy_q) begin
      if (rs >= {1'b0, d_q}) begin
        r_q <= 32'(rs - {1'b0, d_q});
        q_q <= {q_q[62:0], 1'b1};
      end else begin
        r_q <= rs[31:0];
        q_q <= {q_q[62:0], 1'b0};
      end
    end
  end

  assign quo_o = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule

### design/tef_back.sv
// tef_back: per-sample angles, smoothing, sums and frame build with byte output
// depends on tef_pkg, tef_cordic, tef_div
module tef_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_pop_o,
  input  tef_pkg::job_t       job_i,
  input  logic [16:0]         gain_i,
  input  logic [14:0]         arm_i,
  input  logic [7:0]          avg_i,
  output logic                out_valid,
  input  logic                out_stall,
  output tef_pkg::out_word_t  out_data_o,
  output logic                idle_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StCord  = 4'd1;
  localparam logic [3:0] StWait  = 4'd2;
  localparam logic [3:0] StAcc   = 4'd3;
  localparam logic [3:0] StDiv   = 4'd4;
  localparam logic [3:0] StDivW  = 4'd5;
  localparam logic [3:0] StSin   = 4'd6;
  localparam logic [3:0] StSinW  = 4'd7;
  localparam logic [3:0] StMul   = 4'd8;
  localparam logic [3:0] StSend  = 4'd9;
  localparam logic [3:0] StScale = 4'd10;

  logic [3:0]  st_q;
  logic [2:0]  k_q;        // cordic job or frame value index
  tef_pkg::job_t j_q;
  logic signed [31:0] ang_q [4];
  logic signed [31:0] sp_q, sr_q;
  logic signed [39:0] scp_q, scr_q, sfp_q, sfr_q;
  logic [7:0]  cnt_q;
  logic [15:0] val_q [6];
  logic [3:0]  byte_q;

  // cordic
  logic               c_start, c_done;
  logic signed [21:0] c_num, c_den;
  logic signed [31:0] c_ang, c_out;
  logic signed [63:0] c_y;
  logic signed [31:0] avg_pitch_q;

  // divider
  logic               d_start, d_done;
  logic signed [63:0] d_num, d_quo;
  logic [31:0]        d_den;

  function automatic logic signed [21:0] mag21(input logic signed [20:0] v);
    return v[20] ? -22'(v) : 22'(v);
  endfunction

  always_comb begin
    case (k_q)
      3'd0: begin c_num = 22'(j_q.cx); c_den = mag21(j_q.cy) + mag21(j_q.cz); end
      3'd1: begin c_num = 22'(j_q.cy); c_den = mag21(j_q.cx) + mag21(j_q.cz); end
      3'd2: begin c_num = 22'(j_q.fx); c_den = mag21(j_q.fy) + mag21(j_q.fz); end
      3'd3: begin c_num = 22'(j_q.fy); c_den = mag21(j_q.fx) + mag21(j_q.fz); end
      default: begin c_num = '0; c_den = '0; end
    endcase
  end

  assign c_ang = avg_pitch_q;

  tef_cordic u_cordic (
    .clk_i, .rst_ni,
    .start_i (c_start),
    .rot_i   (st_q == StSin),
    .num_i   (c_num),
    .den_i   (c_den),
    .ang_i   (c_ang),
    .done_o  (c_done),
    .y_o     (c_y),
    .ang_o   (c_out)
  );

  tef_div u_div (
    .clk_i, .rst_ni,
    .start_i (d_start),
    .num_i   (d_num),
    .den_i   (d_den),
    .done_o  (d_done),
    .quo_o   (d_quo)
  );

  assign c_start = (st_q == StCord) || (st_q == StSin);
  assign d_start = (st_q == StDiv);

  // frame value k: 0 cp, 1 cr, 2 cpos, 3 fp, 4 fr, 5 fpos
  logic signed [39:0] sel_sum;
  logic               is_pos;
  logic signed [47:0] prod_q, pos;
  logic signed [31:0] c_y32;
  logic signed [15:0] arm_s;
  always_comb begin
    case (k_q)
      3'd0, 3'd2: sel_sum = scp_q;
      3'd1:       sel_sum = scr_q;
      3'd3, 3'd5: sel_sum = sfp_q;
      3'd4:       sel_sum = sfr_q;
      default:    sel_sum = '0;
    endcase
    is_pos = (k_q == 3'd2) || (k_q == 3'd5);
    if (is_pos) begin
      d_num = 64'(sel_sum);
      d_den = 32'(cnt_q);
    end else begin
      d_num = 64'(sel_sum) * 64'sd100;
      d_den = {8'd0, cnt_q, 16'd0};
    end
  end

  // sine in q30 times arm length, truncated toward zero by the shift
  assign c_y32 = c_y[31:0];
  assign arm_s = $signed({1'b0, arm_i});
  assign pos   = (prod_q + (prod_q[47] ? 48'sh3FFF_FFFF : 48'sd0)) >>> tef_pkg::SineShift;

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'h7FFF;
    if (v < -64'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  // smoother
  logic [16:0]        g;
  logic signed [32:0] dp, dr;
  logic signed [51:0] mp, mr;
  assign g  = (gain_i > 17'd65536) ? 17'd65536 : gain_i;
  assign dp = 33'(ang_q[0]) - 33'(sp_q);
  assign dr = 33'(ang_q[1]) - 33'(sr_q);
  assign mp = 52'($signed({1'b0, g})) * 52'(dp) + 52'sd32768;
  assign mr = 52'($signed({1'b0, g})) * 52'(dr) + 52'sd32768;

  logic [7:0] limit, cnt_n;
  assign limit = (avg_i == 8'd0) ? 8'd1 : avg_i;
  assign cnt_n = cnt_q + 8'd1;

  assign job_pop_o = (st_q == StIdle) && job_valid_i;
  assign idle_o    = (st_q == StIdle);

  always_ff @(posedge clk_i) begin
    if (job_pop_o) j_q <= job_i;
    if (c_done && st_q == StWait) ang_q[k_q[1:0]] <= c_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      k_q   <= '0;
      byte_q <= '0;
      sp_q <= '0; sr_q <= '0;
      scp_q <= '0; scr_q <= '0; sfp_q <= '0; sfr_q <= '0;
      cnt_q <= '0;
      avg_pitch_q <= '0;
      prod_q <= '0;
      for (int v = 0; v < 6; v++) val_q[v] <= '0;
    end else begin
      case (st_q)
        StIdle: if (job_valid_i) begin
          st_q <= StCord;
          k_q  <= '0;
        end
        StCord: st_q <= StWait;
        StWait: if (c_done) begin
          if (k_q == 3'd3) st_q <= StAcc;
          else begin
            k_q  <= k_q + 3'd1;
            st_q <= StCord;
          end
        end
        StAcc: begin
          sp_q  <= sp_q + 32'(mp >>> 16);
          sr_q  <= sr_q + 32'(mr >>> 16);
          scp_q <= scp_q + 40'(sp_q + 32'(mp >>> 16));
          scr_q <= scr_q + 40'(sr_q + 32'(mr >>> 16));
          sfp_q <= sfp_q + 40'(ang_q[2]);
          sfr_q <= sfr_q + 40'(ang_q[3]);
          cnt_q <= cnt_n;
          k_q   <= '0;
          st_q  <= (cnt_n < limit) ? StIdle : StDiv;
        end
        StDiv: st_q <= StDivW;
        StDivW: if (d_done) begin
          if (is_pos) begin
            avg_pitch_q <= 32'(d_quo);
            st_q <= StSin;
          end else begin
            val_q[k_q] <= sat16(d_quo);
            if (k_q == 3'd5) begin
              st_q   <= StSend;
              byte_q <= '0;
            end else begin
              k_q  <= k_q + 3'd1;
              st_q <= StDiv;
            end
          end
        end
        StSin: st_q <= StSinW;
        StSinW: if (c_done) st_q <= StMul;
        StMul: begin
          prod_q <= 48'(c_y32) * 48'(arm_s);
          st_q   <= StScale;
        end
        StScale: begin
          val_q[k_q] <= sat16(64'(pos));
          if (k_q == 3'd5) begin
            st_q   <= StSend;
            byte_q <= '0;
          end else begin
            k_q  <= k_q + 3'd1;
            st_q <= StDiv;
          end
        end
        StSend: if (!out_stall) begin
          if (byte_q == 4'(tef_pkg::FrameLen - 1)) begin
            st_q <= StIdle;
            scp_q <= '0; scr_q <= '0; sfp_q <= '0; sfr_q <= '0;
            cnt_q <= '0;
          end
          byte_q <= byte_q + 4'd1;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  logic [2:0] vi;
  assign vi = 3'((byte_q - 4'd1) >> 1);
  assign out_valid = (st_q == StSend);
  always_comb begin
    if (byte_q == 4'd0) out_data_o.frame_byte = tef_pkg::FrameHeader;
    else if (byte_q[0]) out_data_o.frame_byte = val_q[vi][15:8];
    else out_data_o.frame_byte = val_q[vi][7:0];
    out_data_o.last_byte = (byte_q == 4'(tef_pkg::FrameLen - 1));
  end

endmodule

### design/tilt_estimator_averaging_framer.sv
// tilt_estimator_averaging_framer: top level, configuration registers, front and back
// depends on tef_pkg, tef_front, tef_back
//
// channel   dir  handshake        payload
// in        in   in_valid/stall   in_data_i, tef_pkg::in_word_t
// out       out  out_valid/stall  out_data_o, tef_pkg::out_word_t
// cfg       in   cfg_valid/ready  cfg_index_i, cfg_data_i
//
// a sample is popped, passes four times through the cordic and is then accumulated
// a closing sample adds four angle divisions and, per position, an averaging
// division, a sine pass, a multiply step and a scaling step
// then 13 frame bytes, each held for as long as the output stalls
// the front queue holds two samples and the back one more; stall rises when the queue is full
// reset is asynchronous and restores the configuration and control registers to their defaults
module tilt_estimator_averaging_framer #(
  parameter int unsigned OneGCounts = tef_pkg::OneGCounts
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  tef_pkg::in_word_t  in_data_i,
  output logic               out_valid,
  input  logic               out_stall,
  output tef_pkg::out_word_t out_data_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic signed [15:0] off_x_q, off_y_q, off_z_q;
  logic [16:0] gain_q;
  logic [14:0] arm_q;
  logic [7:0]  avg_q;
  logic        job_valid, job_pop, idle;
  tef_pkg::job_t job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0; off_y_q <= '0; off_z_q <= '0;
      gain_q  <= 17'd18350;
      arm_q   <= 15'd50;
      avg_q   <= 8'd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_i)
        tef_pkg::RegOffsetX: off_x_q <= cfg_data_i[15:0];
        tef_pkg::RegOffsetY: off_y_q <= cfg_data_i[15:0];
        tef_pkg::RegOffsetZ: off_z_q <= cfg_data_i[15:0];
        tef_pkg::RegGain:    gain_q  <= cfg_data_i[16:0];
        tef_pkg::RegArm:     arm_q   <= cfg_data_i[14:0];
        tef_pkg::RegAvg:     avg_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  tef_front #(.OneG(OneGCounts)) u_front (
    .clk_i, .rst_ni,
    .in_valid, .in_stall, .in_data_i,
    .off_x_i (off_x_q), .off_y_i (off_y_q), .off_z_i (off_z_q),
    .job_valid_o (job_valid), .job_pop_i (job_pop), .job_o (job)
  );

  tef_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (job_valid), .job_pop_o (job_pop), .job_i (job),
    .gain_i (gain_q), .arm_i (arm_q), .avg_i (avg_q),
    .out_valid, .out_stall, .out_data_o,
    .idle_o (idle)
  );

`ifndef ASSERT_OFF
  a_pop_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_valid) else $error("pop from empty queue");
  a_out_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !idle) else $error("output while idle");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_stall && out_data_o.last_byte |=> !out_valid)
    else $error("frame did not end");
`endif

endmodule
